@@ sv/plst_pkg.sv @@
package plst_pkg;

	// Store geometry
	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	// Stream field widths
	localparam int CMD_W  = 2;
	localparam int POS_W  = 5;
	localparam int ITEM_W = 32;
	localparam int READ_W = 32;
	localparam int STAT_W = 2;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD_POSITION = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL         = 2'd2;

	// Broadcast control from the command decode to every cell
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [POS_W-1:0] pos;
	} cell_ctl_t;

	// One result item
	typedef struct packed {
		logic [CNT_W-1:0]  count_now;
		logic [STAT_W-1:0] status;
		logic [READ_W-1:0] read_value;
	} result_t;

endpackage

@@ sv/plst_cell.sv @@
module plst_cell
	import plst_pkg::*;
(
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic [IDX_W-1:0]      cell_idx,
	input  logic [DATA_WIDTH-1:0] prev_data,
	input  logic [DATA_WIDTH-1:0] next_data,
	input  logic [DATA_WIDTH-1:0] new_data,
	output logic [DATA_WIDTH-1:0] data_q
);

	logic [POS_W-1:0] idx_ext;

	assign idx_ext = POS_W'(cell_idx);

	// Insert: cells above the position take the lower neighbor, the cell at it
	// takes the new word. Remove: cells at and above take the upper neighbor.
	always_ff @(posedge clk) begin
		if (ctl.ins && (idx_ext > ctl.pos)) begin
			data_q <= prev_data;
		end else if (ctl.ins && (idx_ext == ctl.pos)) begin
			data_q <= new_data;
		end else if (ctl.rem && (idx_ext >= ctl.pos)) begin
			data_q <= next_data;
		end
	end

endmodule

@@ sv/positional_list_store_core.sv @@
// A result is registered into the output queue (out_q, or skid_q while out_q is stalled) when its command transfers.
// Throughput: one command per cycle while s_axis_tready is high; all cells shift or hold in parallel.
// A two-deep output queue keeps input flowing while one result is stalled.
// Reset (arst_n low, asynchronous): count 0, output queue empty.
// Cell contents are not cleared; only entries below the count are read.
module positional_list_store_core
	import plst_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [1:0] command, [6:2] position, [38:7] item_value, [39] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [31:0] read_value, [33:32] status, [38:34] count_now, [39] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic [CMD_W-1:0]      command;
	logic [POS_W-1:0]      position;
	logic [ITEM_W-1:0]     item_value;
	logic                  accept;
	logic                  take;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_d;
	logic [POS_W-1:0]      count_ext;
	logic                  pos_in_list;
	logic                  pos_at_ins;
	logic                  full;
	cell_ctl_t             ctl;
	result_t               res;
	result_t               out_q;
	result_t               skid_q;
	logic                  out_v_q;
	logic                  skid_v_q;
	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

	assign command    = s_axis_tdata[1:0];
	assign position   = s_axis_tdata[6:2];
	assign item_value = s_axis_tdata[38:7];

	assign s_axis_tready = !skid_v_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign take          = out_v_q && m_axis_tready;

	// Position checks against the current count
	assign count_ext   = POS_W'(count_q);
	assign pos_in_list = position < count_ext;
	assign pos_at_ins  = position <= count_ext;
	assign full        = count_q == CNT_W'(CAPACITY);

	// Command decode and result
	always_comb begin
		ctl.ins        = 1'b0;
		ctl.rem        = 1'b0;
		ctl.pos        = position;
		res.read_value = '0;
		res.status     = ST_OK;
		count_d        = count_q;
		case (command)
			CMD_INSERT: begin
				if (!pos_at_ins) begin
					res.status = ST_BAD_POSITION;
				end else if (full) begin
					res.status = ST_FULL;
				end else begin
					ctl.ins = accept;
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_REMOVE: begin
				if (!pos_in_list) begin
					res.status = ST_BAD_POSITION;
				end else begin
					ctl.rem = accept;
					count_d = count_q - CNT_W'(1);
				end
			end
			CMD_GET: begin
				if (!pos_in_list) begin
					res.status = ST_BAD_POSITION;
				end else begin
					res.read_value = READ_W'(cell_data[position[IDX_W-1:0]]);
				end
			end
			default: begin
				res.status = ST_BAD_POSITION;
			end
		endcase
		res.count_now = count_d;
	end

	// Row of storage cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_w;
		logic [DATA_WIDTH-1:0] next_w;
		if (i == 0) begin : g_first
			assign prev_w = '0;
		end else begin : g_mid_lo
			assign prev_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_w = '0;
		end else begin : g_mid_hi
			assign next_w = cell_data[i+1];
		end
		plst_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.cell_idx  (IDX_W'(i)),
			.prev_data (prev_w),
			.next_data (next_w),
			.new_data  (item_value[DATA_WIDTH-1:0]),
			.data_q    (cell_data[i])
		);
	end

	// Count and output queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (take || !out_v_q) begin
				if (skid_v_q) begin
					out_v_q  <= 1'b1;
					skid_v_q <= accept;
				end else begin
					out_v_q <= accept;
				end
			end else if (accept) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	// Output queue payload
	always_ff @(posedge clk) begin
		if (take || !out_v_q) begin
			if (skid_v_q) begin
				out_q  <= skid_q;
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {1'b0, out_q.count_now, out_q.status, out_q.read_value};

endmodule

@@ sv/plst_checker.sv @@
module plst_checker
	import plst_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Input is only back-pressured while a result is pending
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no pending result");

	// Count never exceeds capacity
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[38:34] <= CNT_W'(CAPACITY)))
		else $error("count above capacity");

	// A full refusal reports a full store
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[33:32] == ST_FULL)
		|-> (m_axis_tdata[38:34] == CNT_W'(CAPACITY)))
		else $error("full status with store not full");

	// Error results carry zero data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[33:32] != ST_OK) |-> (m_axis_tdata[31:0] == '0))
		else $error("error result with nonzero data");

endmodule

bind positional_list_store_core plst_checker u_plst_checker (.*);
